### rtl/fcsm_pkg.sv
// Package for the flash command state machine: command codes, decoder and
// sequencer state types, and the decoder-to-sequencer info struct.
// Depends on nothing; the decoder, the top level and the testbench import it.
`timescale 1ns / 1ps
`default_nettype none

package fcsm_pkg;

	localparam logic [15:0] ADDR_UNLOCK1 = 16'h5555;
	localparam logic [15:0] ADDR_UNLOCK2 = 16'h2AAA;
	localparam logic [15:0] ADDR_BANK_SEL = 16'h0000;
	localparam logic [7:0] DATA_UNLOCK1 = 8'hAA;
	localparam logic [7:0] DATA_UNLOCK2 = 8'h55;
	localparam logic [7:0] CMD_AUTOSELECT = 8'h90;
	localparam logic [7:0] CMD_ERASE_SETUP = 8'h80;
	localparam logic [7:0] CMD_RESET = 8'hF0;
	localparam logic [7:0] CMD_PROGRAM = 8'hA0;
	localparam logic [7:0] CMD_BANK_SELECT = 8'hB0;
	localparam logic [7:0] CMD_SECTOR_ERASE = 8'h30;
	localparam logic [7:0] CMD_CHIP_ERASE = 8'h10;
	localparam logic [7:0] MFR_ID_ONE_BANK = 8'h32;
	localparam logic [7:0] MFR_ID_TWO_BANK = 8'h62;
	localparam logic [7:0] DEV_ID_ONE_BANK = 8'h1B;
	localparam logic [7:0] DEV_ID_TWO_BANK = 8'h13;
	localparam logic [7:0] ID_ADDR_MFR = 8'h00;
	localparam logic [7:0] ID_ADDR_DEV = 8'h01;
	localparam logic [7:0] ERASED_BYTE = 8'hFF;
	localparam logic [7:0] ZERO_BYTE = 8'h00;

	localparam logic FUNC_READ = 1'b0;
	localparam logic FUNC_WRITE = 1'b1;

	localparam logic CFG_TWO_BANKS = 1'b0;
	localparam logic CFG_ERASE_FILL = 1'b1;

	typedef enum logic [3:0] {
		PH_ARRAY = 4'd0,
		PH_CMD1 = 4'd1,
		PH_CMD2 = 4'd2,
		PH_AUTO = 4'd3,
		PH_CMD3 = 4'd4,
		PH_CMD4 = 4'd5,
		PH_CMD5 = 4'd6,
		PH_PROG = 4'd8,
		PH_BANK = 4'd9
	} phase_t;

	typedef enum logic [1:0] {
		RM_ARRAY = 2'd0,
		RM_AUTO = 2'd1,
		RM_ERASED = 2'd2
	} rmode_t;

	typedef enum logic [1:0] {
		ACT_NONE = 2'd0,
		ACT_PROGRAM = 2'd1,
		ACT_SECTOR = 2'd2,
		ACT_CHIP = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_CLEAR = 2'd0,
		ST_IDLE = 2'd1,
		ST_READ = 2'd2,
		ST_ERASE = 2'd3
	} seq_state_t;

	typedef struct packed {
		action_t action;
		logic bank;
		logic rd_from_mem;
		logic [7:0] rd_value;
	} cmd_info_t;

endpackage

`default_nettype wire

### rtl/fcsm_store.sv
// Single-port byte store for the flash cells with a registered read.
// Depends on nothing; the top level instantiates it.
`timescale 1ns / 1ps
`default_nettype none

module fcsm_store #(
	parameter int DEPTH = 131072,
	parameter int AW = 17
) (
	input wire logic clk,
	input wire logic we,
	input wire logic re,
	input wire logic [AW-1:0] addr,
	input wire logic [7:0] wdata,
	output logic [7:0] rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### rtl/fcsm_cmd.sv
// Command decoder: phase, read mode and active bank registers, and the
// per-beat decode of reads and command writes. Depends on fcsm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fcsm_cmd (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic accept,
	input wire logic func,
	input wire logic [15:0] bus_address,
	input wire logic [7:0] write_data,
	input wire logic dual,
	input wire logic two_banks,
	output fcsm_pkg::cmd_info_t info
);
	import fcsm_pkg::*;

	phase_t phase_q, phase_d;
	rmode_t mode_q, mode_d;
	logic bank_q, bank_d;

	always_comb begin
		phase_d = phase_q;
		mode_d = mode_q;
		bank_d = bank_q;
		if (func == FUNC_READ) begin
			if (mode_q == RM_ERASED) begin
				phase_d = PH_ARRAY;
				mode_d = RM_ARRAY;
			end
		end else begin
			case (phase_q)
				PH_ARRAY: begin
					if (bus_address == ADDR_UNLOCK1 && write_data == DATA_UNLOCK1) begin
						phase_d = PH_CMD1;
					end
				end
				PH_CMD1: begin
					if (bus_address == ADDR_UNLOCK2 && write_data == DATA_UNLOCK2) begin
						phase_d = PH_CMD2;
					end else begin
						phase_d = PH_ARRAY;
					end
				end
				PH_CMD2: begin
					phase_d = PH_ARRAY;
					mode_d = RM_ARRAY;
					if (bus_address == ADDR_UNLOCK1) begin
						if (write_data == CMD_AUTOSELECT) begin
							phase_d = PH_AUTO;
							mode_d = RM_AUTO;
						end else if (write_data == CMD_ERASE_SETUP) begin
							phase_d = PH_CMD3;
							mode_d = mode_q;
						end else if (write_data == CMD_PROGRAM) begin
							phase_d = PH_PROG;
							mode_d = mode_q;
						end else if (write_data == CMD_BANK_SELECT && dual) begin
							phase_d = PH_BANK;
							mode_d = mode_q;
						end
					end
				end
				PH_CMD3: begin
					if (bus_address == ADDR_UNLOCK1 && write_data == DATA_UNLOCK1) begin
						phase_d = PH_CMD4;
					end else begin
						phase_d = PH_ARRAY;
						mode_d = RM_ARRAY;
					end
				end
				PH_CMD4: begin
					if (bus_address == ADDR_UNLOCK2 && write_data == DATA_UNLOCK2) begin
						phase_d = PH_CMD5;
					end else begin
						phase_d = PH_ARRAY;
						mode_d = RM_ARRAY;
					end
				end
				PH_CMD5: begin
					if (write_data == CMD_SECTOR_ERASE || write_data == CMD_CHIP_ERASE) begin
						mode_d = RM_ERASED;
					end else begin
						phase_d = PH_ARRAY;
						mode_d = RM_ARRAY;
					end
				end
				PH_AUTO: begin
					if (write_data != CMD_RESET && bus_address == ADDR_UNLOCK1
							&& write_data == DATA_UNLOCK1) begin
						phase_d = PH_CMD1;
					end else begin
						phase_d = PH_ARRAY;
						mode_d = RM_ARRAY;
					end
				end
				PH_BANK: begin
					if (bus_address == ADDR_BANK_SEL) begin
						bank_d = write_data[0];
					end
					phase_d = PH_ARRAY;
					mode_d = RM_ARRAY;
				end
				default: begin
					phase_d = PH_ARRAY;
					mode_d = RM_ARRAY;
				end
			endcase
		end
	end

	always_comb begin
		info.action = ACT_NONE;
		info.bank = dual & bank_q;
		info.rd_from_mem = 1'b0;
		info.rd_value = ZERO_BYTE;
		if (func == FUNC_READ) begin
			case (mode_q)
				RM_ARRAY: info.rd_from_mem = 1'b1;
				RM_AUTO: begin
					if (bus_address[7:0] == ID_ADDR_MFR) begin
						info.rd_value = two_banks ? MFR_ID_TWO_BANK : MFR_ID_ONE_BANK;
					end else if (bus_address[7:0] == ID_ADDR_DEV) begin
						info.rd_value = two_banks ? DEV_ID_TWO_BANK : DEV_ID_ONE_BANK;
					end
				end
				RM_ERASED: info.rd_value = ERASED_BYTE;
				default: info.rd_value = ZERO_BYTE;
			endcase
		end else begin
			case (phase_q)
				PH_PROG: info.action = ACT_PROGRAM;
				PH_CMD5: begin
					if (write_data == CMD_SECTOR_ERASE) begin
						info.action = ACT_SECTOR;
					end else if (write_data == CMD_CHIP_ERASE) begin
						info.action = ACT_CHIP;
					end
				end
				default: info.action = ACT_NONE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ARRAY;
			mode_q <= RM_ARRAY;
			bank_q <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			mode_q <= mode_d;
			bank_q <= bank_d;
		end
	end

endmodule

`default_nettype wire

### rtl/flash_command_state_machine.sv
// Top level of the flash command state machine: configuration registers,
// the sweep sequencer and the output register. Depends on fcsm_pkg,
// fcsm_cmd and fcsm_store.
//
// Each input beat is one bus access (func, bus_address, write_data). A read
// gives one output beat on read_data; a write gives none and drives the
// command decoder. Configuration is written through cfg_we, cfg_index and
// cfg_data with no wait.
// A write that changes only the decoder leaves the sequencer idle. A read
// is registered first (the store read or the decoded value) and then loaded
// into the output register. Program writes the store in the cycle of the beat.
// Erases run one address counter over the store, one byte per cycle: a sector
// erase covers one sector, a chip erase one bank or, with two banks in use,
// the whole store. in_stall is high while a beat is at work. After reset the
// same counter fills all NUM_BANKS * BANK_BYTES bytes with 0xFF before the
// first beat is taken. A stalled output beat holds; a read then waits for
// the output register to drain and holds in_stall high, so writes are taken
// only while no read waits. BANK_BYTES and SECTOR_BYTES must be powers of
// two; the block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module flash_command_state_machine #(
	parameter int BANK_BYTES = 65536,
	parameter int NUM_BANKS = 2,
	parameter int SECTOR_BYTES = 4096
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic func,
	input wire logic [15:0] bus_address,
	input wire logic [7:0] write_data,
	output logic out_valid,
	input wire logic out_stall,
	output logic [7:0] read_data,
	input wire logic cfg_we,
	input wire logic [0:0] cfg_index,
	input wire logic [7:0] cfg_data
);
	import fcsm_pkg::*;

	localparam int MEM_DEPTH = NUM_BANKS * BANK_BYTES;
	localparam int AW = $clog2(MEM_DEPTH);
	localparam int OW = $clog2(BANK_BYTES);
	localparam int SEC_SPAN = (SECTOR_BYTES < BANK_BYTES) ? SECTOR_BYTES : BANK_BYTES;
	localparam logic [OW-1:0] SEC_MASK = OW'(SEC_SPAN - 1);
	localparam logic [AW-1:0] LAST_ALL = AW'(MEM_DEPTH - 1);
	localparam logic [AW-1:0] LAST_BANK0 = AW'(BANK_BYTES - 1);

	seq_state_t state_q, state_d;
	cmd_info_t info;
	logic two_banks_q;
	logic [7:0] erase_fill_q;
	logic [7:0] fill_q;
	logic [AW-1:0] sweep_addr_q;
	logic [AW-1:0] last_q;
	logic rd_from_mem_q;
	logic [7:0] rd_value_q;
	logic out_valid_q;
	logic [7:0] read_data_q;
	logic dual;
	logic in_accept;
	logic out_load;
	logic sweep_done;
	logic [OW-1:0] beat_off;
	logic [AW-1:0] beat_addr;
	logic mem_we;
	logic mem_re;
	logic [AW-1:0] mem_addr;
	logic [7:0] mem_wdata;
	logic [7:0] mem_rdata;

	assign dual = two_banks_q && (NUM_BANKS > 1);
	assign in_accept = in_valid && !in_stall;
	assign beat_off = bus_address[OW-1:0];
	assign beat_addr = AW'({info.bank, beat_off});
	assign sweep_done = (sweep_addr_q == last_q);

	fcsm_cmd u_cmd (
		.clk(clk),
		.arst_n(arst_n),
		.accept(in_accept),
		.func(func),
		.bus_address(bus_address),
		.write_data(write_data),
		.dual(dual),
		.two_banks(two_banks_q),
		.info(info)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sweep_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_accept) begin
					if (func == FUNC_READ) begin
						state_d = ST_READ;
					end else if (info.action == ACT_SECTOR || info.action == ACT_CHIP) begin
						state_d = ST_ERASE;
					end
				end
			end
			ST_READ: begin
				if (!out_valid_q || !out_stall) begin
					state_d = ST_IDLE;
				end
			end
			ST_ERASE: begin
				if (sweep_done) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		out_load = 1'b0;
		mem_we = 1'b0;
		mem_re = 1'b0;
		mem_addr = beat_addr;
		mem_wdata = write_data;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_addr = sweep_addr_q;
				mem_wdata = ERASED_BYTE;
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				mem_we = in_accept && (info.action == ACT_PROGRAM);
				mem_re = in_accept && (func == FUNC_READ) && info.rd_from_mem;
			end
			ST_READ: out_load = !out_valid_q || !out_stall;
			ST_ERASE: begin
				mem_we = 1'b1;
				mem_addr = sweep_addr_q;
				mem_wdata = fill_q;
			end
			default: in_stall = 1'b1;
		endcase
	end

	fcsm_store #(
		.DEPTH(MEM_DEPTH),
		.AW(AW)
	) u_store (
		.clk(clk),
		.we(mem_we),
		.re(mem_re),
		.addr(mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			sweep_addr_q <= '0;
			last_q <= LAST_ALL;
			two_banks_q <= 1'b0;
			erase_fill_q <= ERASED_BYTE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_index == CFG_TWO_BANKS) begin
					two_banks_q <= cfg_data[0];
				end else if (cfg_index == CFG_ERASE_FILL) begin
					erase_fill_q <= cfg_data;
				end
			end
			if ((state_q == ST_CLEAR || state_q == ST_ERASE) && !sweep_done) begin
				sweep_addr_q <= sweep_addr_q + AW'(1);
			end else if (in_accept && info.action == ACT_SECTOR) begin
				sweep_addr_q <= AW'({info.bank, beat_off & ~SEC_MASK});
				last_q <= AW'({info.bank, beat_off | SEC_MASK});
			end else if (in_accept && info.action == ACT_CHIP) begin
				sweep_addr_q <= '0;
				last_q <= dual ? LAST_ALL : LAST_BANK0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			rd_from_mem_q <= info.rd_from_mem;
			rd_value_q <= info.rd_value;
			fill_q <= erase_fill_q;
		end
		if (out_load) begin
			read_data_q <= rd_from_mem_q ? mem_rdata : rd_value_q;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;

	a_sweep_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ERASE && !sweep_done) |=> (sweep_addr_q == $past(sweep_addr_q) + AW'(1)))
		else $error("erase sweep did not advance by one address");

	a_sweep_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ERASE) |-> (sweep_addr_q <= last_q))
		else $error("erase sweep ran past its last address");

	a_port_single: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !mem_re)
		else $error("store written and read in the same cycle");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_READ))
		else $error("output beat raised outside a read");

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for flash_command_state_machine: a predictor of the
// command decoder and the cell store checks every read beat. Depends on fcsm_pkg
// and the flash_command_state_machine RTL.
`timescale 1ns / 1ps

module tb;
	import fcsm_pkg::*;

	localparam int BANK_BYTES = 65536;
	localparam int NUM_BANKS = 2;
	localparam int SECTOR_BYTES = 4096;
	localparam int CW = $clog2(NUM_BANKS * BANK_BYTES);
	localparam int unsigned CYCLE_LIMIT = 4000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic func = 1'b0;
	logic [15:0] bus_address = 16'h0000;
	logic [7:0] write_data = 8'h00;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] read_data;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_index = 1'b0;
	logic [7:0] cfg_data = 8'h00;

	flash_command_state_machine #(
		.BANK_BYTES(BANK_BYTES),
		.NUM_BANKS(NUM_BANKS),
		.SECTOR_BYTES(SECTOR_BYTES)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.bus_address(bus_address),
		.write_data(write_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.read_data(read_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	phase_t cur_phase;
	rmode_t cur_rmode;
	logic sel_bank;
	logic cfg_two_banks;
	logic [7:0] cfg_fill;
	logic [7:0] cells [0:NUM_BANKS * BANK_BYTES - 1];
	logic [7:0] expected_read_bytes [$];

	logic [15:0] hot_addr [0:7];
	bit idle_on = 1'b1;
	int stall_left = 0;
	int settle_cycles = 16;
	int beats_sent = 0;
	int ignored_beats = 0;
	int sector_erases_left = 40;
	int chip_erases_left = 1;
	int mismatches = 0;
	int unsigned cycle_count = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic void flash_reset();
		for (int i = 0; i < NUM_BANKS * BANK_BYTES; i++)
			cells[CW'(i)] = 8'hFF;
		cur_phase = PH_ARRAY;
		cur_rmode = RM_ARRAY;
		sel_bank = 1'b0;
		cfg_two_banks = 1'b0;
		cfg_fill = 8'hFF;
	endfunction

	function automatic int cell_index(input logic [15:0] a);
		return ((cfg_two_banks && sel_bank) ? BANK_BYTES : 0) + int'(a);
	endfunction

	function automatic void back_to_array();
		cur_phase = PH_ARRAY;
		cur_rmode = RM_ARRAY;
	endfunction

	function automatic logic [7:0] flash_read(input logic [15:0] a);
		case (cur_rmode)
			RM_ARRAY: return cells[CW'(cell_index(a))];
			RM_AUTO: begin
				if (a[7:0] == ID_ADDR_MFR)
					return cfg_two_banks ? MFR_ID_TWO_BANK : MFR_ID_ONE_BANK;
				if (a[7:0] == ID_ADDR_DEV)
					return cfg_two_banks ? DEV_ID_TWO_BANK : DEV_ID_ONE_BANK;
				return ZERO_BYTE;
			end
			RM_ERASED: begin
				back_to_array();
				return ERASED_BYTE;
			end
			default: return ZERO_BYTE;
		endcase
	endfunction

	function automatic void flash_write(input logic [15:0] a, input logic [7:0] d);
		int base;
		int span;
		case (cur_phase)
			PH_ARRAY: begin
				if (a == ADDR_UNLOCK1 && d == DATA_UNLOCK1)
					cur_phase = PH_CMD1;
			end
			PH_CMD1: begin
				cur_phase = (a == ADDR_UNLOCK2 && d == DATA_UNLOCK2) ? PH_CMD2 : PH_ARRAY;
			end
			PH_CMD2: begin
				if (a != ADDR_UNLOCK1)
					back_to_array();
				else if (d == CMD_AUTOSELECT) begin
					cur_phase = PH_AUTO;
					cur_rmode = RM_AUTO;
				end else if (d == CMD_ERASE_SETUP)
					cur_phase = PH_CMD3;
				else if (d == CMD_PROGRAM)
					cur_phase = PH_PROG;
				else if (d == CMD_BANK_SELECT && cfg_two_banks)
					cur_phase = PH_BANK;
				else
					back_to_array();
			end
			PH_CMD3: begin
				if (a == ADDR_UNLOCK1 && d == DATA_UNLOCK1)
					cur_phase = PH_CMD4;
				else
					back_to_array();
			end
			PH_CMD4: begin
				if (a == ADDR_UNLOCK2 && d == DATA_UNLOCK2)
					cur_phase = PH_CMD5;
				else
					back_to_array();
			end
			PH_CMD5: begin
				if (d == CMD_SECTOR_ERASE) begin
					base = cell_index({a[15:12], 12'h000});
					for (int i = 0; i < SECTOR_BYTES; i++)
						cells[CW'(base + i)] = cfg_fill;
					cur_rmode = RM_ERASED;
				end else if (d == CMD_CHIP_ERASE) begin
					span = cfg_two_banks ? 2 * BANK_BYTES : BANK_BYTES;
					for (int i = 0; i < span; i++)
						cells[CW'(i)] = cfg_fill;
					cur_rmode = RM_ERASED;
				end else
					back_to_array();
			end
			PH_AUTO: begin
				if (d == CMD_RESET)
					back_to_array();
				else if (a == ADDR_UNLOCK1 && d == DATA_UNLOCK1)
					cur_phase = PH_CMD1;
				else
					back_to_array();
			end
			PH_PROG: begin
				cells[CW'(cell_index(a))] = d;
				back_to_array();
			end
			PH_BANK: begin
				if (a == ADDR_BANK_SEL)
					sel_bank = d[0];
				back_to_array();
			end
			default: back_to_array();
		endcase
	endfunction

	function automatic void flash_access(input logic f, input logic [15:0] a,
			input logic [7:0] d);
		if (f == FUNC_READ)
			expected_read_bytes.push_back(flash_read(a));
		else
			flash_write(a, d);
	endfunction

	function automatic logic [15:0] pick_addr();
		logic [15:0] r;
		r = 16'($urandom);
		if ($urandom_range(0, 1) == 0)
			r = hot_addr[3'($urandom_range(0, 7))];
		return r;
	endfunction

	// Every task below is entered at a falling edge and returns at one.
	task automatic send_access(input logic f, input logic [15:0] a, input logic [7:0] d);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		bus_address <= a;
		write_data <= d;
		do
			@(posedge clk);
		while (in_stall);
		if (f == FUNC_WRITE && cur_phase == PH_CMD5 && d == CMD_CHIP_ERASE)
			settle_cycles = (cfg_two_banks ? 2 * BANK_BYTES : BANK_BYTES) + 64;
		else if (f == FUNC_WRITE && cur_phase == PH_CMD5 && d == CMD_SECTOR_ERASE)
			settle_cycles = SECTOR_BYTES + 64;
		else
			settle_cycles = 16;
		flash_access(f, a, d);
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic send_unlock();
		send_access(FUNC_WRITE, ADDR_UNLOCK1, DATA_UNLOCK1);
		send_access(FUNC_WRITE, ADDR_UNLOCK2, DATA_UNLOCK2);
	endtask

	task automatic send_erase_prefix(input int steps);
		for (int i = 0; i < steps; i++) begin
			case (i)
				0, 3: send_access(FUNC_WRITE, ADDR_UNLOCK1, DATA_UNLOCK1);
				1, 4: send_access(FUNC_WRITE, ADDR_UNLOCK2, DATA_UNLOCK2);
				default: send_access(FUNC_WRITE, ADDR_UNLOCK1, CMD_ERASE_SETUP);
			endcase
		end
	endtask

	// Erases are costly, so random traffic spends them from a fixed budget.
	task automatic rnd_write(input logic [15:0] a, input logic [7:0] d);
		logic [7:0] v;
		v = d;
		if (cur_phase == PH_CMD5 && v == CMD_CHIP_ERASE) begin
			if (chip_erases_left == 0)
				v = CMD_SECTOR_ERASE;
			else
				chip_erases_left--;
		end
		if (cur_phase == PH_CMD5 && v == CMD_SECTOR_ERASE) begin
			if (sector_erases_left == 0)
				v = ZERO_BYTE;
			else
				sector_erases_left--;
		end
		send_access(FUNC_WRITE, a, v);
	endtask

	task automatic wait_for_quiet();
		in_valid <= 1'b0;
		while (expected_read_bytes.size() != 0)
			@(negedge clk);
		repeat (settle_cycles) @(negedge clk);
		settle_cycles = 16;
	endtask

	task automatic load_config(input logic two, input logic [7:0] fill);
		cfg_we <= 1'b1;
		cfg_index <= CFG_TWO_BANKS;
		cfg_data <= {7'b0, two};
		@(negedge clk);
		cfg_index <= CFG_ERASE_FILL;
		cfg_data <= fill;
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_two_banks = two;
		cfg_fill = fill;
	endtask

	task automatic test_program_extremes();
		wait_for_quiet();
		load_config(1'b0, 8'hFF);
		send_access(FUNC_READ, 16'h0000, 8'h00);
		send_unlock();
		send_access(FUNC_WRITE, ADDR_UNLOCK1, CMD_PROGRAM);
		send_access(FUNC_WRITE, 16'hFFFF, 8'h00);
		send_access(FUNC_READ, 16'hFFFF, 8'hFF);
	endtask

	task automatic test_autoselect();
		send_unlock();
		send_access(FUNC_WRITE, ADDR_UNLOCK1, CMD_AUTOSELECT);
		send_access(FUNC_READ, 16'h0000, 8'h00);
		send_access(FUNC_READ, 16'hFF01, 8'h00);
		send_access(FUNC_READ, 16'h1202, 8'h00);
		// A broken unlock drops the phase but keeps the ID bytes readable.
		send_access(FUNC_WRITE, ADDR_UNLOCK1, DATA_UNLOCK1);
		send_access(FUNC_WRITE, ADDR_UNLOCK2, 8'h00);
		send_access(FUNC_READ, 16'h0001, 8'h00);
		// Bank select is refused on the one-bank part and returns to array.
		send_unlock();
		send_access(FUNC_WRITE, ADDR_UNLOCK1, CMD_BANK_SELECT);
		send_access(FUNC_READ, 16'hFFFF, 8'h00);
	endtask

	task automatic test_bank_select();
		wait_for_quiet();
		load_config(1'b1, 8'h00);
		send_unlock();
		send_access(FUNC_WRITE, ADDR_UNLOCK1, CMD_BANK_SELECT);
		send_access(FUNC_WRITE, ADDR_BANK_SEL, 8'hFF);
		send_access(FUNC_READ, 16'hFFFF, 8'h00);
	endtask

	task automatic test_chip_erase_two_banks();
		send_erase_prefix(5);
		send_access(FUNC_WRITE, 16'h0000, CMD_CHIP_ERASE);
		send_access(FUNC_READ, 16'h1000, 8'h00);
		send_access(FUNC_READ, 16'h1000, 8'h00);
	endtask

	task automatic test_repeated_erase();
		wait_for_quiet();
		load_config(1'b0, 8'hA5);
		send_erase_prefix(5);
		send_access(FUNC_WRITE, 16'hF123, CMD_SECTOR_ERASE);
		send_access(FUNC_WRITE, 16'h7777, CMD_CHIP_ERASE);
		send_access(FUNC_READ, 16'hF000, 8'h00);
		send_access(FUNC_READ, 16'hF000, 8'h00);
	endtask

	task automatic test_random_traffic(input logic two, input logic [7:0] fill,
			input int n_items, input bit with_idle);
		int target;
		int sel;
		int k;
		logic [15:0] a;
		wait_for_quiet();
		load_config(two, fill);
		idle_on = with_idle;
		hot_addr[0] = 16'h0000;
		hot_addr[1] = 16'hFFFF;
		for (int i = 2; i < 8; i++)
			hot_addr[3'(i)] = 16'($urandom);
		target = beats_sent - ignored_beats + n_items;
		while (beats_sent - ignored_beats < target) begin
			sel = $urandom_range(0, 99);
			if (sel < 30)
				send_access(FUNC_READ, pick_addr(), 8'($urandom));
			else if (sel < 55) begin
				a = pick_addr();
				send_unlock();
				rnd_write(ADDR_UNLOCK1, CMD_PROGRAM);
				rnd_write(a, 8'($urandom));
				if ($urandom_range(0, 1) == 0)
					send_access(FUNC_READ, a, 8'($urandom));
			end else if (sel < 65) begin
				send_unlock();
				rnd_write(ADDR_UNLOCK1, CMD_AUTOSELECT);
				repeat ($urandom_range(1, 3)) begin
					a = 16'($urandom);
					k = $urandom_range(0, 2);
					if (k < 2)
						a[7:0] = 8'(k);
					send_access(FUNC_READ, a, 8'($urandom));
				end
				k = $urandom_range(0, 9);
				if (k < 4)
					rnd_write(16'($urandom), CMD_RESET);
				else if (k < 7)
					rnd_write(ADDR_UNLOCK1, DATA_UNLOCK1);
			end else if (sel < 73) begin
				send_unlock();
				rnd_write(ADDR_UNLOCK1, CMD_BANK_SELECT);
				rnd_write(($urandom_range(0, 3) != 0) ? ADDR_BANK_SEL : pick_addr(),
					8'($urandom));
			end else if (sel < 79) begin
				send_erase_prefix(5);
				rnd_write(pick_addr(), CMD_SECTOR_ERASE);
				if ($urandom_range(0, 3) == 0)
					rnd_write(pick_addr(), CMD_SECTOR_ERASE);
				if ($urandom_range(0, 4) != 0)
					send_access(FUNC_READ, pick_addr(), 8'($urandom));
			end else if (sel < 80) begin
				send_erase_prefix(5);
				rnd_write(pick_addr(), CMD_CHIP_ERASE);
				send_access(FUNC_READ, pick_addr(), 8'($urandom));
			end else if (sel < 90) begin
				send_erase_prefix($urandom_range(1, 5));
				if ($urandom_range(0, 9) < 7)
					rnd_write(pick_addr(), 8'($urandom));
				else
					send_access(FUNC_READ, pick_addr(), 8'($urandom));
			end else begin
				rnd_write(16'($urandom),
					($urandom_range(0, 3) == 0) ? CMD_RESET : 8'($urandom));
				ignored_beats++;
			end
		end
	endtask

	always @(negedge clk) begin
		if (stall_left > 0)
			stall_left--;
		else if (idle_on && $urandom_range(0, 5) == 0)
			stall_left = $urandom_range(1, 8);
		out_stall <= (stall_left > 0);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_read_bytes.size() == 0) begin
				$error("read_data beat with nothing expected: expected none, actual %02h",
					read_data);
				mismatches++;
			end else if (expected_read_bytes[0] !== read_data) begin
				$error("read_data mismatch: expected %02h, actual %02h",
					expected_read_bytes[0], read_data);
				mismatches++;
				void'(expected_read_bytes.pop_front());
			end else
				void'(expected_read_bytes.pop_front());
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		flash_reset();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_program_extremes();
		test_autoselect();
		test_bank_select();
		test_chip_erase_two_banks();
		test_repeated_erase();
		test_random_traffic(1'b1, 8'h00, 340, 1'b1);
		test_random_traffic(1'b0, 8'hFF, 340, 1'b1);
		test_random_traffic(1'b1, 8'($urandom), 340, 1'b1);
		test_random_traffic(1'b0, 8'($urandom), 340, 1'b1);
		test_random_traffic(1'b1, 8'hFF, 340, 1'b0);
		wait_for_quiet();
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
